// ----- rtl/lbsi_pkg.sv -----
// Shared types and constants for the link box subdivide/inflate core.
package lbsi_pkg;

  localparam int NUM_AXES   = 3;
  localparam int NUM_BOUNDS = 2 * NUM_AXES;  // lo x,y,z then hi x,y,z
  localparam int CFG_W      = 7;
  localparam int RADIUS_W   = 31;
  localparam int IDX_W      = 6;
  localparam int RADIX_BITS = 4;             // quotient bits per divider cycle

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_DIV,
    ST_FIX,
    ST_PRIME,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store_prox;
    logic load_diff;
    logic div_load;
    logic div_step;
    logic div_fix;
    logic advance;
    logic emit;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_last;
    logic seg_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/link_box_subdivide_inflate_core.sv -----
// Top level of the link box subdivide/inflate core.
// A request with in_is_distal low stores the proximal endpoint box. A request
// with in_is_distal high pairs with the stored box and produces segment_count sub-boxes
// (zero counts as one, values above MAX_SEGMENTS clamp), each bound interpolated with floor
// division between the two boxes and inflated by in_link_radius, saturated to the coordinate
// range. A distal request latches the difference to the stored box, then runs the radix-16
// divider that forms the per-segment step of all six bounds in parallel, applies the floor
// correction and primes the first sample point, after which one sub-box leaves per cycle
// through the output register while the output is not stalled. The next request is taken
// while the last sub-box still waits in the output register.
module link_box_subdivide_inflate_core import lbsi_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_is_distal,
  input  logic signed [COORD_WIDTH-1:0] in_box_lo_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_lo_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_lo_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_hi_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_hi_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_hi_z,
  input  logic [RADIUS_W-1:0]           in_link_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_seg_lo_x,
  output logic signed [COORD_WIDTH-1:0] out_seg_lo_y,
  output logic signed [COORD_WIDTH-1:0] out_seg_lo_z,
  output logic signed [COORD_WIDTH-1:0] out_seg_hi_x,
  output logic signed [COORD_WIDTH-1:0] out_seg_hi_y,
  output logic signed [COORD_WIDTH-1:0] out_seg_hi_z,
  output logic [IDX_W-1:0]              out_segment_index,
  output logic                          out_last_segment
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [NUM_BOUNDS-1:0][COORD_WIDTH-1:0] in_box;
  logic [NUM_BOUNDS-1:0][COORD_WIDTH-1:0] out_box;

  // Bound order: lo x,y,z then hi x,y,z
  assign in_box = {in_box_hi_z, in_box_hi_y, in_box_hi_x,
                   in_box_lo_z, in_box_lo_y, in_box_lo_x};

  assign out_seg_lo_x = out_box[0];
  assign out_seg_lo_y = out_box[1];
  assign out_seg_lo_z = out_box[2];
  assign out_seg_hi_x = out_box[3];
  assign out_seg_hi_y = out_box[4];
  assign out_seg_hi_z = out_box[5];

  lbsi_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_is_distal (in_is_distal),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  lbsi_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_box            (in_box),
    .in_link_radius    (in_link_radius),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_box           (out_box),
    .out_segment_index (out_segment_index),
    .out_last_segment  (out_last_segment)
  );

endmodule

// ----- rtl/lbsi_ctrl.sv -----
// Controller state machine: sequences load, divide, step setup and segment emission.
module lbsi_ctrl import lbsi_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_is_distal,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_is_distal) begin
            cmd.load_diff = 1'b1;
            state_nxt     = ST_ABS;
          end else begin
            cmd.store_prox = 1'b1;
          end
        end
      end
      ST_ABS: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = ST_PRIME;
      end
      ST_PRIME: begin
        cmd.advance = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.advance = 1'b1;
          if (sts.seg_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lbsi_dp.sv -----
// Datapath: proximal store, per-bound step divider, incremental interpolation, output register.
module lbsi_dp import lbsi_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  dp_cmd_t                                 cmd,
  output dp_sts_t                                 sts,
  input  logic                                    cfg_wr_en,
  input  logic [CFG_W-1:0]                        cfg_wr_data,
  input  logic [NUM_BOUNDS-1:0][COORD_WIDTH-1:0]  in_box,
  input  logic [RADIUS_W-1:0]                     in_link_radius,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [NUM_BOUNDS-1:0][COORD_WIDTH-1:0]  out_box,
  output logic [IDX_W-1:0]                        out_segment_index,
  output logic                                    out_last_segment
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int NW    = $clog2(MAX_SEGMENTS + 1);
  localparam int ITER  = (DW + RADIX_BITS - 1) / RADIX_BITS;
  localparam int MW    = ITER * RADIX_BITS;
  localparam int ITW   = (ITER > 1) ? $clog2(ITER) : 1;
  localparam int EW    = ((COORD_WIDTH > RADIUS_W) ? COORD_WIDTH : RADIUS_W) + 2;

  localparam logic signed [EW-1:0] SAT_HI = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic [CFG_W-1:0]    seg_count_r;
  logic [CW-1:0]       prox_r  [NUM_BOUNDS];
  logic [DW-1:0]       diff_r  [NUM_BOUNDS];
  logic [RADIUS_W-1:0] radius_r;
  logic [NW-1:0]       n_r;
  logic [NW-1:0]       n_clamp;

  logic [MW-1:0]       num_r   [NUM_BOUNDS];
  logic [MW-1:0]       quo_r   [NUM_BOUNDS];
  logic [NW-1:0]       rem_r   [NUM_BOUNDS];
  logic                neg_r   [NUM_BOUNDS];
  logic [ITW-1:0]      it_r;

  logic [MW-1:0]       num_nxt [NUM_BOUNDS];
  logic [MW-1:0]       quo_nxt [NUM_BOUNDS];
  logic [NW-1:0]       rem_nxt [NUM_BOUNDS];
  logic [DW-1:0]       mag     [NUM_BOUNDS];
  logic [DW-1:0]       diff_nxt[NUM_BOUNDS];

  logic [CW-1:0]       qd_r    [NUM_BOUNDS];
  logic [NW-1:0]       rd_r    [NUM_BOUNDS];
  logic [CW-1:0]       qd_nxt  [NUM_BOUNDS];
  logic [NW-1:0]       rd_nxt  [NUM_BOUNDS];

  logic [NW-1:0]       acc_r   [NUM_BOUNDS];
  logic [NW-1:0]       acc_nxt [NUM_BOUNDS];
  logic [CW-1:0]       vcur_r  [NUM_BOUNDS];
  logic [CW-1:0]       vnxt_r  [NUM_BOUNDS];
  logic [CW-1:0]       vnxt_nxt[NUM_BOUNDS];

  logic [NW-1:0]       seg_r;
  logic [NW+IDX_W-1:0] seg_ext;
  logic                out_valid_r;
  logic [CW-1:0]       out_box_r [NUM_BOUNDS];
  logic [CW-1:0]       out_box_nxt [NUM_BOUNDS];
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_last_r;
  logic                seg_last;

  // Segment count clamp: zero means one, above the maximum means the maximum
  always_comb begin
    if (seg_count_r == '0) begin
      n_clamp = NW'(1);
    end else if (int'(seg_count_r) > MAX_SEGMENTS) begin
      n_clamp = NW'(MAX_SEGMENTS);
    end else begin
      n_clamp = NW'(seg_count_r);
    end
  end

  // Distal minus proximal, and its magnitude for the divider
  always_comb begin
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      diff_nxt[i] = {in_box[i][CW-1], in_box[i]} - {prox_r[i][CW-1], prox_r[i]};
      mag[i]      = diff_r[i][DW-1] ? (~diff_r[i] + DW'(1)) : diff_r[i];
    end
  end

  // Divider: RADIX_BITS restoring steps per cycle on each lane
  always_comb begin
    logic [NW:0]    part;
    logic [MW-1:0]  num;
    logic [MW-1:0]  quo;
    logic [NW-1:0]  rem;
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      num = num_r[i];
      quo = quo_r[i];
      rem = rem_r[i];
      for (int j = 0; j < RADIX_BITS; j++) begin
        part = {rem, num[MW-1]};
        num  = num << 1;
        if (part >= {1'b0, n_r}) begin
          part = part - {1'b0, n_r};
          quo  = {quo[MW-2:0], 1'b1};
        end else begin
          quo  = {quo[MW-2:0], 1'b0};
        end
        rem = part[NW-1:0];
      end
      num_nxt[i] = num;
      quo_nxt[i] = quo;
      rem_nxt[i] = rem;
    end
  end

  // Floor correction of the quotient for a negative difference
  always_comb begin
    logic [CW-1:0] qa;
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      qa = quo_r[i][CW-1:0];
      if (neg_r[i] && (rem_r[i] != '0)) begin
        qd_nxt[i] = ~qa;
        rd_nxt[i] = n_r - rem_r[i];
      end else if (neg_r[i]) begin
        qd_nxt[i] = ~qa + CW'(1);
        rd_nxt[i] = '0;
      end else begin
        qd_nxt[i] = qa;
        rd_nxt[i] = rem_r[i];
      end
    end
  end

  // One interpolation step: value += quotient step plus remainder carry
  always_comb begin
    logic [NW:0] rsum;
    logic        carry;
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      rsum  = {1'b0, acc_r[i]} + {1'b0, rd_r[i]};
      carry = (rsum >= {1'b0, n_r});
      if (carry) begin
        rsum = rsum - {1'b0, n_r};
      end
      acc_nxt[i]  = rsum[NW-1:0];
      vnxt_nxt[i] = vnxt_r[i] + qd_r[i] + CW'(carry);
    end
  end

  // Hull of the two sample points, inflated by the radius, saturated
  always_comb begin
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] m;
    logic signed [EW-1:0] rad_s;
    logic signed [EW-1:0] val;
    rad_s = EW'(radius_r);
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      a = vcur_r[i];
      b = vnxt_r[i];
      if (i < NUM_AXES) begin
        m   = (a < b) ? a : b;
        val = EW'(m) - rad_s;
      end else begin
        m   = (a > b) ? a : b;
        val = EW'(m) + rad_s;
      end
      if (val > SAT_HI) begin
        val = SAT_HI;
      end else if (val < SAT_LO) begin
        val = SAT_LO;
      end
      out_box_nxt[i] = val[CW-1:0];
    end
  end

  assign seg_last = (seg_r == (n_r - NW'(1)));
  assign seg_ext  = {{IDX_W{1'b0}}, seg_r};

  // Control state and registers with a defined reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= CFG_W'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        prox_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        seg_count_r <= cfg_wr_data;
      end
      if (cmd.store_prox) begin
        for (int i = 0; i < NUM_BOUNDS; i++) begin
          prox_r[i] <= in_box[i];
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_diff) begin
      radius_r <= in_link_radius;
      n_r      <= n_clamp;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        diff_r[i] <= diff_nxt[i];
      end
    end
    if (cmd.div_load) begin
      it_r <= ITW'(ITER - 1);
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        num_r[i] <= MW'(mag[i]);
        quo_r[i] <= '0;
        rem_r[i] <= '0;
        neg_r[i] <= diff_r[i][DW-1];
      end
    end
    if (cmd.div_step) begin
      it_r <= it_r - ITW'(1);
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        num_r[i] <= num_nxt[i];
        quo_r[i] <= quo_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
    if (cmd.div_fix) begin
      seg_r <= '0;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        qd_r[i]   <= qd_nxt[i];
        rd_r[i]   <= rd_nxt[i];
        vnxt_r[i] <= prox_r[i];
        acc_r[i]  <= '0;
      end
    end
    if (cmd.advance) begin
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        vcur_r[i] <= vnxt_r[i];
        vnxt_r[i] <= vnxt_nxt[i];
        acc_r[i]  <= acc_nxt[i];
      end
    end
    if (cmd.emit) begin
      seg_r      <= seg_r + NW'(1);
      out_idx_r  <= seg_ext[IDX_W-1:0];
      out_last_r <= seg_last;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        out_box_r[i] <= out_box_nxt[i];
      end
    end
  end

  // Outputs and status
  always_comb begin
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      out_box[i] = out_box_r[i];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_index = out_idx_r;
  assign out_last_segment  = out_last_r;

  assign sts.div_last = (it_r == '0);
  assign sts.seg_last = seg_last;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule
